// ----- rtl/itfr_pkg.sv -----
// Package for the idle-timeout frame receiver.
// Request and result payload types, item kinds and the control-to-datapath structs.
// No dependencies.
`default_nettype none

package itfr_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_BYTE    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RELEASE = 2'd3
  } itfr_func_t;

  typedef struct packed {
    itfr_func_t  func;
    logic [7:0]  rx_byte;
    logic [7:0]  read_index;
  } itfr_in_t;

  typedef struct packed {
    logic        frame_ready;
    logic [7:0]  frame_length;
    logic [7:0]  read_byte;
    logic        byte_stored;
    logic        byte_dropped;
    logic        timeout_event;
  } itfr_out_t;

  // Per-request status produced by the frame controller
  typedef struct packed {
    logic        frame_ready;
    logic [7:0]  frame_length;
    logic        byte_stored;
    logic        byte_dropped;
    logic        timeout_event;
  } itfr_stat_t;

  // Buffer write request from the frame controller
  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [7:0]  data;
  } itfr_wr_t;

  localparam int unsigned IdleWidth = 17;
  localparam logic [IdleWidth-1:0] IdleMax = {IdleWidth{1'b1}};
  localparam logic [15:0] TimeoutReset = 16'd10;

endpackage

`default_nettype wire

// ----- rtl/idle_timeout_frame_receiver.sv -----
// Idle-timeout frame receiver: bytes are gathered into a frame that closes after
// the line idles past cfg_wdata ticks or a byte arrives at a full buffer. One
// request is taken every clock unless in_stall is high; each result passes the
// registered buffer read and then the output register. The input accepts while
// a finished result waits, stalling only when the read stage and the output
// register both hold results and out_stall is high. No clearing pass after
// reset. Depends on itfr_pkg, itfr_ctrl and itfr_buf.
`default_nettype none

module idle_timeout_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire itfr_pkg::itfr_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output itfr_pkg::itfr_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata
);
  import itfr_pkg::*;

  logic       acc;
  logic       p_adv;
  logic       p_valid_r, p_valid_nxt;
  logic       o_valid_r, o_valid_nxt;
  itfr_stat_t stat;
  itfr_stat_t p_stat_r;
  logic       p_rd_r;
  itfr_wr_t   wr;
  itfr_out_t  o_data_r;
  logic [7:0] rd_byte;
  logic       rd_acc;

  assign p_adv       = p_valid_r && (!o_valid_r || !out_stall);
  assign in_stall    = p_valid_r && o_valid_r && out_stall;
  assign acc         = in_valid && !in_stall;
  assign rd_acc      = acc && (in_data.func == FUNC_READ);
  assign p_valid_nxt = acc || (p_valid_r && !p_adv);
  assign o_valid_nxt = p_adv || (o_valid_r && out_stall);

  itfr_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .wr        (wr)
  );

  itfr_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_acc  (rd_acc),
    .rd_idx  (in_data.read_index),
    .rd_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_stat_r <= stat;
      p_rd_r   <= rd_acc;
    end
    if (p_adv) begin
      o_data_r.frame_ready   <= p_stat_r.frame_ready;
      o_data_r.frame_length  <= p_stat_r.frame_length;
      o_data_r.read_byte     <= p_rd_r ? rd_byte : 8'd0;
      o_data_r.byte_stored   <= p_stat_r.byte_stored;
      o_data_r.byte_dropped  <= p_stat_r.byte_dropped;
      o_data_r.timeout_event <= p_stat_r.timeout_event;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

`default_nettype wire

// ----- rtl/itfr_ctrl.sv -----
// Frame controller: byte count, closed flag, idle counter and timeout register.
// Updates state on each accepted request and produces its status and buffer write.
// Depends on itfr_pkg.
`default_nettype none

module itfr_ctrl #(
  parameter int unsigned BUFFER_DEPTH = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire itfr_pkg::itfr_in_t   req,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata,
  output itfr_pkg::itfr_stat_t      stat,
  output itfr_pkg::itfr_wr_t        wr
);
  import itfr_pkg::*;

  localparam logic [7:0] DepthCnt = 8'(BUFFER_DEPTH);

  logic [7:0]           cnt_r, cnt_nxt;
  logic                 closed_r, closed_nxt;
  logic [IdleWidth-1:0] idle_r, idle_nxt;
  logic [15:0]          tmo_r;
  logic [IdleWidth-1:0] idle_inc;
  logic                 held;
  logic                 timed_tick;
  logic                 timed_now;

  assign held       = (cnt_r != 8'd0);
  assign idle_inc   = (idle_r == IdleMax) ? idle_r : idle_r + 1'b1;
  assign timed_tick = held && (idle_inc > {1'b0, tmo_r});
  assign timed_now  = held && (idle_r > {1'b0, tmo_r});

  always_comb begin
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    idle_nxt   = idle_r;
    stat       = '0;
    wr.en      = 1'b0;
    wr.idx     = cnt_r;
    wr.data    = req.rx_byte;
    unique case (req.func)
      FUNC_TICK: begin
        idle_nxt = idle_inc;
        if (timed_tick) begin
          closed_nxt         = 1'b1;
          stat.timeout_event = 1'b1;
        end
      end
      FUNC_BYTE: begin
        if (closed_r) begin
          stat.byte_dropped = 1'b1;
        end else if (timed_now || cnt_r >= DepthCnt) begin
          closed_nxt        = 1'b1;
          stat.byte_dropped = 1'b1;
        end else begin
          wr.en            = 1'b1;
          cnt_nxt          = cnt_r + 8'd1;
          idle_nxt         = '0;
          stat.byte_stored = 1'b1;
        end
      end
      FUNC_READ: begin
      end
      FUNC_RELEASE: begin
        if (closed_r) begin
          cnt_nxt    = 8'd0;
          closed_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    stat.frame_ready  = closed_nxt;
    stat.frame_length = closed_nxt ? cnt_nxt : 8'd0;
    if (!acc) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 8'd0;
      closed_r <= 1'b0;
      idle_r   <= '0;
      tmo_r    <= TimeoutReset;
    end else begin
      if (acc) begin
        cnt_r    <= cnt_nxt;
        closed_r <= closed_nxt;
        idle_r   <= idle_nxt;
      end
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itfr_buf.sv -----
// Frame byte buffer: one write port, one registered read port.
// Reads outside the buffer depth return zero.
// Depends on itfr_pkg.
`default_nettype none

module itfr_buf #(
  parameter int unsigned BUFFER_DEPTH = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire itfr_pkg::itfr_wr_t  wr,
  input  wire logic                rd_acc,
  input  wire logic [7:0]          rd_idx,
  output logic [7:0]               rd_byte
);
  import itfr_pkg::*;

  localparam int unsigned AddrWidth = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [7:0]  DepthCnt  = 8'(BUFFER_DEPTH);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_r;
  logic       hit_r;
  logic       hit;

  assign hit = rd_idx < DepthCnt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AddrWidth-1:0]] <= wr.data;
    end
    if (rd_acc && hit) begin
      rdata_r <= mem[rd_idx[AddrWidth-1:0]];
    end
  end

  // hit_r marks whether this request's read returns data or zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_acc) begin
      hit_r <= hit;
    end
  end

  assign rd_byte = hit_r ? rdata_r : 8'd0;

endmodule

`default_nettype wire
